// ===== rtl/jset_pkg.sv =====
// Julia set escape-time engine: shared package.
// Holds widths, register indexes, state encodings, the start-point type
// and the signed saturation helper. Depends on nothing.
package jset_pkg;

    localparam int FRAC_BITS    = 27;
    localparam int IDX_W        = 12;
    localparam int DIM_CFG_W    = 13;
    localparam int COORD_W      = 32;
    localparam int COUNT_W      = 8;
    localparam int QUOT_W       = IDX_W + FRAC_BITS;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;
    localparam int DEF_MAX_ITER = 256;
    localparam int DEF_DIM_MAX  = 4096;

    localparam logic [COORD_W-1:0] WIDTH_RESET  = COORD_W'(640);
    localparam logic [COORD_W-1:0] HEIGHT_RESET = COORD_W'(480);

    // Configuration register index (word address)
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SEED_REAL    = 2'd2,
        REG_SEED_IMAG    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_MUL,
        C_ADD,
        C_SQ,
        C_CMP,
        C_DONE
    } core_state_t;

    // Start point of one pixel in Q5.27
    typedef struct packed {
        logic signed [COORD_W-1:0] re;
        logic signed [COORD_W-1:0] im;
    } start_pt_t;

    // Saturate a signed 64-bit value to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[COORD_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/jset_fifo.sv =====
// Julia set engine: small register queue with push/full and pop/empty.
// Used between front and back, and for results. Depends on nothing.
module jset_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] data_in,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] data_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (cnt_reg == (AW+1)'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Store the request
    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

// ===== rtl/jset_front.sv =====
// Julia set engine: front part. Accepts a pixel, divides column and row by
// the clamped frame size one quotient bit a cycle, and queues the start point.
// Depends on jset_pkg.
module jset_front
    import jset_pkg::*;
#(
    parameter int DIM_MAX = DEF_DIM_MAX
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [IDX_W-1:0]     pixel_column,
    input  logic [IDX_W-1:0]     pixel_row,
    input  logic [DIM_CFG_W-1:0] frame_width,
    input  logic [DIM_CFG_W-1:0] frame_height,
    input  logic                 q_full,
    output logic                 q_push,
    output start_pt_t            q_data
);

    localparam int DIV_W = $clog2(DIM_MAX + 1);
    localparam int CMP_W = (DIV_W > DIM_CFG_W) ? DIV_W : DIM_CFG_W;
    localparam int CNT_W = $clog2(QUOT_W + 1);
    localparam int SUM_W = QUOT_W + 4;

    front_state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] dcol_reg, drow_reg;
    logic [QUOT_W-1:0] qcol_reg, qrow_reg;
    logic [DIV_W:0]   rcol_reg, rrow_reg;
    logic             accept;
    logic [DIV_W:0]   rcol_sh, rrow_sh;
    logic signed [SUM_W-1:0] x_wide, y_wide;

    function automatic logic [DIV_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] d);
        logic [CMP_W-1:0] dx;
        dx = CMP_W'(d);
        if (dx == '0) begin
            clamp_dim = DIV_W'(1);
        end else if (dx > CMP_W'(DIM_MAX)) begin
            clamp_dim = DIV_W'(DIM_MAX);
        end else begin
            clamp_dim = DIV_W'(dx);
        end
    endfunction

    assign full   = (state_reg != F_IDLE);
    assign accept = push && !full;

    // Shift in next dividend bit
    assign rcol_sh = {rcol_reg[DIV_W-1:0], qcol_reg[QUOT_W-1]};
    assign rrow_sh = {rrow_reg[DIV_W-1:0], qrow_reg[QUOT_W-1]};

    // Map quotients to Q5.27 start point
    assign x_wide = $signed(SUM_W'(qcol_reg) * SUM_W'(3)) - $signed(SUM_W'(3) <<< 26);
    assign y_wide = $signed(SUM_W'(qrow_reg) <<< 1) - $signed(SUM_W'(1) <<< FRAC_BITS);
    assign q_data.re = sat32(64'(x_wide));
    assign q_data.im = sat32(64'(y_wide));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and queue push
    always_comb begin
        state_next = state_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_DIV;
                end
            end
            F_DIV: begin
                if (cnt_reg == CNT_W'(QUOT_W - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                q_push = !q_full;
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Restoring division, one quotient bit per cycle for both coordinates
    always_ff @(posedge clk) begin
        if (accept) begin
            cnt_reg  <= '0;
            dcol_reg <= clamp_dim(frame_width);
            drow_reg <= clamp_dim(frame_height);
            qcol_reg <= {pixel_column, FRAC_BITS'(0)};
            qrow_reg <= {pixel_row, FRAC_BITS'(0)};
            rcol_reg <= '0;
            rrow_reg <= '0;
        end else if (state_reg == F_DIV) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (rcol_sh >= (DIV_W+1)'(dcol_reg)) begin
                rcol_reg <= rcol_sh - (DIV_W+1)'(dcol_reg);
                qcol_reg <= {qcol_reg[QUOT_W-2:0], 1'b1};
            end else begin
                rcol_reg <= rcol_sh;
                qcol_reg <= {qcol_reg[QUOT_W-2:0], 1'b0};
            end
            if (rrow_sh >= (DIV_W+1)'(drow_reg)) begin
                rrow_reg <= rrow_sh - (DIV_W+1)'(drow_reg);
                qrow_reg <= {qrow_reg[QUOT_W-2:0], 1'b1};
            end else begin
                rrow_reg <= rrow_sh;
                qrow_reg <= {qrow_reg[QUOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== rtl/jset_core.sv =====
// Julia set engine: back part. Iterates z = z^2 + seed on one start point,
// through products, add, squares and compare per iteration, and hands the
// escape count to the result queue. Depends on jset_pkg.
module jset_core
    import jset_pkg::*;
#(
    parameter int MAX_ITER = DEF_MAX_ITER
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [COORD_W-1:0] seed_real,
    input  logic signed [COORD_W-1:0] seed_imag,
    input  logic                      q_empty,
    output logic                      q_pop,
    input  start_pt_t                 q_data,
    input  logic                      r_full,
    output logic                      r_push,
    output logic [COUNT_W-1:0]        r_data
);

    localparam int CNT_W = $clog2(MAX_ITER + 1);
    localparam logic [63:0] ESC_LIMIT = 64'd4 << 54;

    core_state_t state_reg, state_next;
    logic signed [COORD_W-1:0] x_reg, y_reg, tx_reg, ty_reg;
    logic signed [63:0]        xx_reg, yy_reg, xy_reg, txx_reg, tyy_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [COUNT_W-1:0]        res_reg;
    logic [CNT_W-1:0]          cnt_inc;
    logic                      escaped;
    logic signed [63:0]        re_sum, im_sum;

    assign cnt_inc = cnt_reg + 1'b1;
    assign escaped = (64'(txx_reg) + 64'(tyy_reg)) > ESC_LIMIT;
    assign re_sum  = ((xx_reg - yy_reg) >>> FRAC_BITS) + 64'(seed_real);
    assign im_sum  = (xy_reg >>> (FRAC_BITS - 1)) + 64'(seed_imag);
    assign r_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and handshakes
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        r_push     = 1'b0;
        unique case (state_reg)
            C_IDLE: begin
                q_pop = !q_empty;
                if (!q_empty) begin
                    state_next = C_MUL;
                end
            end
            C_MUL: state_next = C_ADD;
            C_ADD: state_next = C_SQ;
            C_SQ:  state_next = C_CMP;
            C_CMP: begin
                if (escaped || (cnt_inc == CNT_W'(MAX_ITER))) begin
                    state_next = C_DONE;
                end else begin
                    state_next = C_MUL;
                end
            end
            C_DONE: begin
                r_push = !r_full;
                if (!r_full) begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    // Iteration datapath
    always_ff @(posedge clk) begin
        case (state_reg)
            C_IDLE: begin
                x_reg   <= q_data.re;
                y_reg   <= q_data.im;
                cnt_reg <= '0;
            end
            C_MUL: begin
                xx_reg <= x_reg * x_reg;
                yy_reg <= y_reg * y_reg;
                xy_reg <= x_reg * y_reg;
            end
            C_ADD: begin
                tx_reg <= sat32(re_sum);
                ty_reg <= sat32(im_sum);
            end
            C_SQ: begin
                txx_reg <= tx_reg * tx_reg;
                tyy_reg <= ty_reg * ty_reg;
            end
            C_CMP: begin
                if (escaped) begin
                    res_reg <= COUNT_W'(cnt_reg);
                end else begin
                    x_reg   <= tx_reg;
                    y_reg   <= ty_reg;
                    cnt_reg <= cnt_inc;
                    res_reg <= '0;
                end
            end
            default: ;
        endcase
    end

    // Count stays within the limit while iterating
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_CMP) |-> (cnt_reg < CNT_W'(MAX_ITER)))
        else $error("iteration count beyond limit");

    // A result leaves only from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        r_push |-> (state_reg == C_DONE))
        else $error("result pushed outside done state");

    // A popped start point starts an iteration
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == C_MUL))
        else $error("start point taken without iterating");

endmodule

// ===== rtl/julia_set_escape_time.sv =====
// Julia set escape-time engine: top level.
// Holds the configuration registers and ties front, back and queues together.
// Depends on jset_pkg, jset_fifo, jset_front and jset_core.
//
// Usage:
//   Input channel: pixel_column/pixel_row with push/full; a request is taken
//   when push is high and full is low. Result channel: escape_count with
//   empty/pop; the oldest result shows while empty is low and leaves on pop.
//   Configuration: APB write of frame_width (0x0), frame_height (0x4),
//   seed_real (0x8), seed_imag (0xC), only while the engine is idle.
// Flow:
//   The front holds full high from a request until it has queued the
//   point: it runs the two coordinate divisions (one quotient bit per
//   cycle), then queues the point, and takes no new request meanwhile.
//   The back runs each iteration through products, add, squares and
//   compare, for at most MAX_ITER iterations per pixel. Front and back
//   overlap through a two-entry queue; throughput is set by the slower
//   of the front's division and the back's loop.
// Reset: all queues empty, registers to 640, 480, 0, 0. No clearing pass.
// Stall: a full result queue holds the back, then the middle queue fills,
//   then full rises at the input.
module julia_set_escape_time
    import jset_pkg::*;
#(
    parameter int MAX_ITER = DEF_MAX_ITER,
    parameter int DIM_MAX  = DEF_DIM_MAX
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  push,
    output logic                  full,
    input  logic [IDX_W-1:0]      pixel_column,
    input  logic [IDX_W-1:0]      pixel_row,
    output logic                  empty,
    input  logic                  pop,
    output logic [COUNT_W-1:0]    escape_count
);

    logic [DIM_CFG_W-1:0]      frame_width_reg, frame_height_reg;
    logic signed [COORD_W-1:0] seed_real_reg, seed_imag_reg;
    cfg_reg_t                  reg_sel;
    logic                      cfg_wr;
    logic                      sq_push, sq_full, sq_pop, sq_empty;
    start_pt_t                 sq_in, sq_out;
    logic                      rq_push, rq_full;
    logic [COUNT_W-1:0]        rq_in;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            frame_width_reg  <= WIDTH_RESET[DIM_CFG_W-1:0];
            frame_height_reg <= HEIGHT_RESET[DIM_CFG_W-1:0];
            seed_real_reg    <= '0;
            seed_imag_reg    <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[DIM_CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[DIM_CFG_W-1:0];
                REG_SEED_REAL:    seed_real_reg    <= pwdata;
                REG_SEED_IMAG:    seed_imag_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_sel)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            REG_SEED_REAL:    prdata = seed_real_reg;
            REG_SEED_IMAG:    prdata = seed_imag_reg;
            default:          prdata = '0;
        endcase
    end

    jset_front #(
        .DIM_MAX (DIM_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_full       (sq_full),
        .q_push       (sq_push),
        .q_data       (sq_in)
    );

    jset_fifo #(
        .WIDTH ($bits(start_pt_t)),
        .DEPTH (2)
    ) u_start_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (sq_push),
        .full     (sq_full),
        .data_in  (sq_in),
        .pop      (sq_pop),
        .empty    (sq_empty),
        .data_out (sq_out)
    );

    jset_core #(
        .MAX_ITER (MAX_ITER)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_real (seed_real_reg),
        .seed_imag (seed_imag_reg),
        .q_empty   (sq_empty),
        .q_pop     (sq_pop),
        .q_data    (sq_out),
        .r_full    (rq_full),
        .r_push    (rq_push),
        .r_data    (rq_in)
    );

    jset_fifo #(
        .WIDTH (COUNT_W),
        .DEPTH (2)
    ) u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (rq_push),
        .full     (rq_full),
        .data_in  (rq_in),
        .pop      (pop),
        .empty    (empty),
        .data_out (escape_count)
    );

endmodule

// ===== test/tb_julia_set_escape_time.sv =====
// Testbench for the Julia set escape-time engine (julia_set_escape_time).
// A directed table, then random phases under several frame and seed settings,
// checked against listed counts or a fixed-point escape predictor. Depends on jset_pkg and julia_set_escape_time.
module tb_julia_set_escape_time
    import jset_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit                 is_cfg;
        cfg_reg_t           idx;
        logic [31:0]        val;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
        bit                 known;
        logic [COUNT_W-1:0] cnt;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push = 1'b0;
    logic                  full;
    logic [IDX_W-1:0]      pixel_column = '0;
    logic [IDX_W-1:0]      pixel_row = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [COUNT_W-1:0]    escape_count;

    // Shadow copy of the configuration
    logic [DIM_CFG_W-1:0]  shadow_width = 13'd640;
    logic [DIM_CFG_W-1:0]  shadow_height = 13'd480;
    logic signed [31:0]    shadow_seed_re = '0;
    logic signed [31:0]    shadow_seed_im = '0;

    logic [COUNT_W-1:0]    pending_counts[$];
    plan_row_t             plan[$];
    bit                    calm = 1'b0;
    int                    errors = 0;
    int                    pixels_sent = 0;
    int                    counts_seen = 0;
    int                    nonzero_seen = 0;
    int                    stall_left = 0;

    julia_set_escape_time dut (.*);

    always #5 clk = ~clk;

    function automatic logic signed [31:0] clip_q527(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint eff_dim(input logic [DIM_CFG_W-1:0] d);
        if (d == 0) return 1;
        if (d > DEF_DIM_MAX) return DEF_DIM_MAX;
        return longint'(d);
    endfunction

    // Escape iteration index of one pixel under the shadow configuration
    function automatic logic [COUNT_W-1:0] julia_escape_count(
        input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        longint             qx;
        longint             qy;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        longint             xx;
        longint             yy;
        longint             xy;
        logic [63:0]        mag;
        int                 i;
        qx = (longint'(col) << FRAC_BITS) / eff_dim(shadow_width);
        qy = (longint'(row) << FRAC_BITS) / eff_dim(shadow_height);
        x = clip_q527(3 * qx - 3 * (64'sd1 <<< 26));
        y = clip_q527(2 * qy - (64'sd1 <<< 27));
        for (i = 0; i < DEF_MAX_ITER; i++) begin
            xx = longint'(x) * longint'(x);
            yy = longint'(y) * longint'(y);
            xy = longint'(x) * longint'(y);
            tx = clip_q527(((xx - yy) >>> FRAC_BITS) + longint'(shadow_seed_re));
            ty = clip_q527((xy >>> (FRAC_BITS - 1)) + longint'(shadow_seed_im));
            mag = 64'(longint'(tx) * longint'(tx)) + 64'(longint'(ty) * longint'(ty));
            if (mag > (64'd4 << 54)) break;
            x = tx;
            y = ty;
        end
        return (i == DEF_MAX_ITER) ? '0 : i[COUNT_W-1:0];
    endfunction

    task automatic report(input string what);
        errors++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    // Drain results, with random pop stalls
    always @(posedge clk) begin
        if (rst_n) begin
            if (pop && !empty) begin
                counts_seen++;
                if (escape_count != 0) nonzero_seen++;
                if (pending_counts.size() == 0) begin
                    report($sformatf("unexpected escape_count %0d", escape_count));
                end else begin
                    if (escape_count !== pending_counts[0])
                        report($sformatf("escape_count %0d, want %0d",
                                         escape_count, pending_counts[0]));
                    void'(pending_counts.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 14);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Write one register over APB; call at a clock edge with the engine idle
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  shadow_width = val[DIM_CFG_W-1:0];
            REG_FRAME_HEIGHT: shadow_height = val[DIM_CFG_W-1:0];
            REG_SEED_REAL:    shadow_seed_re = val;
            REG_SEED_IMAG:    shadow_seed_im = val;
        endcase
        // Leave the bus idle before returning
        @(posedge clk);
    endtask

    // Wait for the engine to drain before touching registers
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_counts.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Send one pixel request, with random gaps before it
    task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row,
                              input bit known, input logic [COUNT_W-1:0] cnt);
        if (!calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        push <= 1'b1;
        pixel_column <= col;
        pixel_row <= row;
        do @(posedge clk); while (full);
        pending_counts.push_back(known ? cnt : julia_escape_count(col, row));
        pixels_sent++;
    endtask

    function automatic plan_row_t cfg_row(input cfg_reg_t idx, input logic [31:0] val);
        plan_row_t r;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        r.col = '0;
        r.row = '0;
        r.known = 1'b0;
        r.cnt = '0;
        return r;
    endfunction

    function automatic plan_row_t pix_row(input int col, input int row,
                                          input bit known, input int cnt);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.idx = REG_FRAME_WIDTH;
        r.val = '0;
        r.col = IDX_W'(col);
        r.row = IDX_W'(row);
        r.known = known;
        r.cnt = COUNT_W'(cnt);
        return r;
    endfunction

    function automatic logic [31:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd4096;
            3: return 32'd8191;
            4: return $urandom_range(0, 8191);
            default: return $urandom_range(8, 96);
        endcase
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'hF999_999A;  // about -0.8
            2: return 32'h0214_5A1D;  // about 0.26
            default: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        endcase
    endfunction

    initial begin
        int ph;
        int n;
        int w;
        int h;
        // Directed table: reset values, divisor corners, saturated seeds
        plan.push_back(pix_row(320, 240, 1, 0));
        plan.push_back(pix_row(0, 0, 1, 0));
        plan.push_back(pix_row(4095, 4095, 1, 0));
        plan.push_back(pix_row(639, 479, 0, 0));
        plan.push_back(pix_row(100, 200, 0, 0));
        plan.push_back(cfg_row(REG_FRAME_WIDTH, 32'd0));
        plan.push_back(cfg_row(REG_FRAME_HEIGHT, 32'd0));
        plan.push_back(pix_row(0, 0, 1, 0));
        plan.push_back(pix_row(1, 1, 1, 0));
        plan.push_back(cfg_row(REG_FRAME_WIDTH, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(REG_FRAME_HEIGHT, 32'd4096));
        plan.push_back(pix_row(2048, 2048, 1, 0));
        plan.push_back(pix_row(4095, 0, 0, 0));
        plan.push_back(cfg_row(REG_SEED_REAL, 32'h7FFF_FFFF));
        plan.push_back(pix_row(2048, 2048, 1, 0));
        plan.push_back(cfg_row(REG_SEED_REAL, 32'h8000_0000));
        plan.push_back(pix_row(2048, 2048, 1, 0));
        plan.push_back(cfg_row(REG_SEED_REAL, 32'hF800_0000));
        plan.push_back(pix_row(2048, 2048, 1, 0));
        plan.push_back(cfg_row(REG_SEED_REAL, 32'h0));
        plan.push_back(cfg_row(REG_SEED_IMAG, 32'h8000_0000));
        plan.push_back(pix_row(2048, 2048, 1, 0));
        plan.push_back(cfg_row(REG_SEED_IMAG, 32'h0214_5A1D));
        plan.push_back(pix_row(1500, 2500, 0, 0));
        plan.push_back(pix_row(3000, 1000, 0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                wait_idle();
                write_reg(plan[k].idx, plan[k].val);
            end else begin
                send_pixel(plan[k].col, plan[k].row, plan[k].known, plan[k].cnt);
            end
        end

        // Random phases; the last runs without gaps or stalls
        for (ph = 0; ph < 8; ph++) begin
            wait_idle();
            calm = (ph == 7);
            write_reg(REG_FRAME_WIDTH, pick_dim());
            write_reg(REG_FRAME_HEIGHT, pick_dim());
            write_reg(REG_SEED_REAL, pick_seed());
            write_reg(REG_SEED_IMAG, pick_seed());
            w = int'(eff_dim(shadow_width));
            h = int'(eff_dim(shadow_height));
            for (n = 0; n < 240; n++) begin
                if ($urandom_range(0, 19) < 17)
                    send_pixel(IDX_W'($urandom_range(0, w - 1)),
                               IDX_W'($urandom_range(0, h - 1)), 1'b0, '0);
                else
                    send_pixel(IDX_W'($urandom_range(0, 4095)),
                               IDX_W'($urandom_range(0, 4095)), 1'b0, '0);
            end
        end
        push <= 1'b0;

        while (pending_counts.size() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        $display("pixels sent %0d, results checked %0d (%0d escaped after iterating)",
                 pixels_sent, counts_seen, nonzero_seen);
        $display("covered reset setup, divisor clamps, saturated seeds, 8 random phases");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
